// File: src/mml_pkg.sv
`default_nettype none
package mml_pkg;

  localparam int unsigned LyricLimit = 30;

  typedef enum logic [3:0] {
    M_IDLE, M_NOTE_HEAD, M_NOTE_LEN, M_NOTE_NUM, M_NOTE_DOT,
    M_NUM_O, M_NUM_Q, M_NUM_L, M_NUM_T, M_L_DOT,
    M_DOLLAR, M_K_SEEK, M_K_TEXT, M_K_ESC, M_SKIP
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE, S_PARSE, S_DIV, S_MUL, S_OUT
  } ctl_state_e;

  localparam logic [1:0] EvNote  = 2'd0;
  localparam logic [1:0] EvRest  = 2'd1;
  localparam logic [1:0] EvError = 2'd2;
  localparam logic [1:0] EvLyric = 2'd3;

  // Division purpose
  localparam logic DivTicks = 1'b0;
  localparam logic DivLen   = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_byte;   // capture input byte
    logic parse;       // run one parse step
    logic div_step;    // one restoring-division step
    logic gate_calc;   // compute gate and tone
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;    // parse step needs a division before continuing
    logic again;       // parse step must re-examine the byte
    logic emit;        // parse step produced an event (note or error)
    logic is_error;    // produced event is an error
    logic div_done;    // division finished
    logic div_len;     // running division is a length; byte is parsed again after it
    logic reparse;     // byte that ended an untied note is parsed again after the event
  } sts_t;

  function automatic logic [31:0] tone_tab(input logic [3:0] i);
    logic [31:0] t;
    begin
      unique case (i)
        4'd0:  t = 32'd1071618315;
        4'd1:  t = 32'd1135340056;
        4'd2:  t = 32'd1202850889;
        4'd3:  t = 32'd1274376125;
        4'd4:  t = 32'd1350154473;
        4'd5:  t = 32'd1430438836;
        4'd6:  t = 32'd1515497155;
        4'd7:  t = 32'd1605613306;
        4'd8:  t = 32'd1701088041;
        4'd9:  t = 32'd1802240000;
        4'd10: t = 32'd1909406767;
        4'd11: t = 32'd2022946002;
        default: t = 32'd0;
      endcase
      return t;
    end
  endfunction

  function automatic logic [3:0] letter_offset(input logic [2:0] i);
    logic [3:0] o;
    begin
      unique case (i)
        3'd0: o = 4'd9;
        3'd1: o = 4'd11;
        3'd2: o = 4'd0;
        3'd3: o = 4'd2;
        3'd4: o = 4'd4;
        3'd5: o = 4'd5;
        3'd6: o = 4'd7;
        default: o = 4'd0;
      endcase
      return o;
    end
  endfunction

endpackage
`default_nettype wire

// File: src/mml_ctrl.sv
`default_nettype none
module mml_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mml_pkg::cmd_t      cmd_o,
  input  wire mml_pkg::sts_t sts_i
);
  import mml_pkg::*;

  ctl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_PARSE;
      S_PARSE: begin
        priority if (sts_i.need_div) state_d = S_DIV;
        else if (sts_i.emit && sts_i.is_error) state_d = S_OUT;
        else if (sts_i.emit) state_d = S_DIV;
        else if (sts_i.again) state_d = S_PARSE;
        else state_d = S_IDLE;
      end
      S_DIV:   if (sts_i.div_done) state_d = sts_i.div_len ? S_PARSE : S_MUL;
      S_MUL:   state_d = S_OUT;
      S_OUT:   if (!out_stall_i) state_d = sts_i.reparse ? S_PARSE : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE:  begin
        in_stall_o      = 1'b0;
        cmd_o.load_byte = in_valid_i;
      end
      S_PARSE: cmd_o.parse = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_MUL:   cmd_o.gate_calc = 1'b1;
      S_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: src/mml_dp.sv
`default_nettype none
module mml_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    mml_byte_i,
  input  wire mml_pkg::cmd_t cmd_i,
  output mml_pkg::sts_t      sts_o,
  output logic [1:0]         event_kind_o,
  output logic [30:0]        tone_value_o,
  output logic               retrigger_o,
  output logic [23:0]        gate_ticks_o,
  output logic [23:0]        total_ticks_o,
  output logic               tied_o
);
  import mml_pkg::*;

  // Architectural state
  logic [3:0]  octave_q, octave_d;
  logic [15:0] dlen_q, dlen_d;
  logic [15:0] tempo_q, tempo_d;
  logic [7:0]  gate_q, gate_d;
  logic [7:0]  prev_q, prev_d;
  mode_e       mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  ppitch_q, ppitch_d;
  logic        prest_q, prest_d;
  logic [15:0] plen_q, plen_d;
  logic [5:0]  lyr_q, lyr_d;
  logic        halt_q, halt_d;
  logic [7:0]  byte_q;

  // Divider: 23-bit dividend, 16-bit divisor, one bit per step
  logic        dpurp_q, dpurp_d;
  logic [22:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic        dtied_q, dtied_d;

  // Result registers
  logic [1:0]  kind_q, kind_d;
  logic [30:0] tone_q, tone_d;
  logic        retr_q, retr_d;
  logic [23:0] gt_q, gt_d;
  logic [23:0] tt_q, tt_d;
  logic        tied_q, tied_d;

  logic is_dig, is_acc, is_start;
  logic [16:0] acc_mul;
  logic [16:0] half_p, half_d;
  logic [7:0]  pitch_w;
  logic [3:0]  pc;
  logic [4:0]  oc;
  logic [18:0] oc_mul;
  logic [7:0]  pc_w;
  logic [30:0] gprod;
  logic        gated;
  logic [16:0] rem_try;
  logic [17:0] sub_w;
  logic [4:0]  shamt;
  logic [21:0] dig_sum;

  assign is_dig  = (byte_q >= 8'h30) && (byte_q <= 8'h39);
  assign is_acc  = (byte_q == 8'h2B) || (byte_q == 8'h23) || (byte_q == 8'h2D);
  // Bytes that begin a command or end the text
  assign is_start = (byte_q >= 8'h41 && byte_q <= 8'h47) || (byte_q == 8'h52)
                    || (byte_q == 8'h3C) || (byte_q == 8'h3E) || (byte_q == 8'h4F)
                    || (byte_q == 8'h51) || (byte_q == 8'h4C) || (byte_q == 8'h54)
                    || (byte_q == 8'h24) || (byte_q == 8'h00);
  // acc * 10 + digit
  assign dig_sum = ({6'b0, acc_q} << 3) + ({6'b0, acc_q} << 1) + {14'b0, byte_q - 8'h30};
  assign acc_mul = (dig_sum > 22'd65535) ? 17'd65535 : dig_sum[16:0];
  assign half_p  = {1'b0, plen_q} + {2'b0, plen_q[15:1]};
  assign half_d  = {1'b0, dlen_q} + {2'b0, dlen_q[15:1]};

  assign rem_try = {rem_q[15:0], quo_q[22]};
  assign sub_w   = {1'b0, rem_try} - {2'b0, dvs_q};

  // Parse step, divider and result formation
  always_comb begin
    octave_d = octave_q; dlen_d = dlen_q; tempo_d = tempo_q; gate_d = gate_q;
    prev_d = prev_q; mode_d = mode_q; acc_d = acc_q; ppitch_d = ppitch_q;
    prest_d = prest_q; plen_d = plen_q; lyr_d = lyr_q; halt_d = halt_q;
    dpurp_d = dpurp_q; quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    dcnt_d = dcnt_q; dtied_d = dtied_q;
    kind_d = kind_q; tone_d = tone_q; retr_d = retr_q; gt_d = gt_q; tt_d = tt_q;
    tied_d = tied_q;
    sts_o = '0;
    sts_o.div_len = (dpurp_q == DivLen);
    // an untied note leaves its ending byte for the next command
    sts_o.reparse = !dtied_q;
    pitch_w = '0; pc = '0; oc = '0; oc_mul = '0; pc_w = '0; gprod = '0;
    gated = 1'b0; shamt = '0;

    if (cmd_i.parse) begin
      if (halt_q) begin
        // ignore byte
      end else begin
        unique case (mode_q)
          M_IDLE: begin
            priority if (byte_q >= 8'h41 && byte_q <= 8'h47) begin
              ppitch_d = {octave_q, 3'b0} + {1'b0, octave_q, 2'b0}
                         + {4'b0, letter_offset(3'(byte_q - 8'h41))} + 8'd12;
              prest_d  = 1'b0;
              mode_d   = M_NOTE_HEAD;
            end else if (byte_q == 8'h52) begin
              ppitch_d = '0; prest_d = 1'b1; mode_d = M_NOTE_HEAD;
            end else if (byte_q == 8'h3C) begin
              octave_d = octave_q - 4'd1;
            end else if (byte_q == 8'h3E) begin
              octave_d = octave_q + 4'd1;
            end else if (byte_q == 8'h4F) begin
              acc_d = '0; mode_d = M_NUM_O;
            end else if (byte_q == 8'h51) begin
              acc_d = '0; mode_d = M_NUM_Q;
            end else if (byte_q == 8'h4C) begin
              acc_d = '0; mode_d = M_NUM_L;
            end else if (byte_q == 8'h54) begin
              acc_d = '0; mode_d = M_NUM_T;
            end else if (byte_q == 8'h24) begin
              mode_d = M_DOLLAR;
            end else if (byte_q != 8'h00) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else begin
            end
          end
          M_NOTE_HEAD: begin
            mode_d = M_NOTE_LEN;
            if (is_acc) begin
              if (!prest_q) ppitch_d = (byte_q == 8'h2D) ? ppitch_q - 8'd1 : ppitch_q + 8'd1;
            end else begin
              sts_o.again = 1'b1;
            end
          end
          M_NOTE_LEN: begin
            if (is_dig) begin
              acc_d = {12'b0, 4'(byte_q - 8'h30)}; mode_d = M_NOTE_NUM;
            end else begin
              plen_d = dlen_q; mode_d = M_NOTE_DOT; sts_o.again = 1'b1;
            end
          end
          M_NOTE_NUM: begin
            if (is_dig) begin
              acc_d = acc_mul[15:0];
            end else if (acc_q == '0) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else begin
              // 192 / acc, then back to the dot state
              sts_o.need_div = 1'b1; dpurp_d = DivLen;
              quo_d = 23'd192; rem_d = '0; dvs_d = acc_q; dcnt_d = 5'd0;
              mode_d = M_NOTE_DOT;
            end
          end
          M_NOTE_DOT: begin
            if (byte_q == 8'h2E) begin
              plen_d = half_p[16] ? 16'hFFFF : half_p[15:0];
            end else if (byte_q != 8'h26 && !is_start) begin
              // unknown byte drops the note; only the error is reported
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else begin
              mode_d = M_IDLE;
              sts_o.emit = 1'b1;
              dtied_d = (byte_q == 8'h26);
              dpurp_d = DivTicks;
              // length * 125
              quo_d = {plen_q, 7'b0} - {5'b0, plen_q, 2'b0} + {7'b0, plen_q};
              rem_d = '0; dvs_d = tempo_q; dcnt_d = 5'd0;
            end
          end
          M_NUM_O, M_NUM_Q, M_NUM_L, M_NUM_T: begin
            if (is_dig) begin
              acc_d = acc_mul[15:0];
            end else begin
              unique case (mode_q)
                M_NUM_O: begin octave_d = acc_q[3:0]; mode_d = M_IDLE; sts_o.again = 1'b1; end
                M_NUM_Q: begin
                  gate_d = (acc_q > 16'd255) ? 8'hFF : acc_q[7:0];
                  mode_d = M_IDLE; sts_o.again = 1'b1;
                end
                M_NUM_T: begin
                  if (acc_q == '0) begin
                    kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
                  end else begin
                    tempo_d = acc_q; mode_d = M_IDLE; sts_o.again = 1'b1;
                  end
                end
                default: begin
                  if (acc_q == '0) begin
                    kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
                  end else begin
                    sts_o.need_div = 1'b1; dpurp_d = DivLen;
                    quo_d = 23'd192; rem_d = '0; dvs_d = acc_q; dcnt_d = 5'd0;
                    mode_d = M_L_DOT;
                  end
                end
              endcase
            end
          end
          M_L_DOT: begin
            if (byte_q == 8'h2E) begin
              dlen_d = half_d[16] ? 16'hFFFF : half_d[15:0];
            end else begin
              mode_d = M_IDLE; sts_o.again = 1'b1;
            end
          end
          M_DOLLAR: begin
            if (byte_q == 8'h00) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else begin
              mode_d = (byte_q == 8'h4B) ? M_K_SEEK : (byte_q == 8'h3B) ? M_IDLE : M_SKIP;
            end
          end
          M_K_SEEK: begin
            if (byte_q == 8'h00) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else if (byte_q == 8'h22) begin
              lyr_d = '0; mode_d = M_K_TEXT;
            end else begin
            end
          end
          M_K_TEXT, M_K_ESC: begin
            if (byte_q == 8'h00) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else if (mode_q == M_K_TEXT && byte_q == 8'h22) begin
              mode_d = M_SKIP;
            end else if (mode_q == M_K_TEXT && byte_q == 8'h25) begin
              mode_d = M_K_ESC;
            end else begin
              lyr_d  = lyr_q + 6'd1;
              mode_d = M_K_TEXT;
              if (lyr_d > 6'(LyricLimit)) begin
                kind_d = EvLyric; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
              end
            end
          end
          M_SKIP: begin
            if (byte_q == 8'h00) begin
              kind_d = EvError; sts_o.emit = 1'b1; sts_o.is_error = 1'b1;
            end else if (byte_q == 8'h3B) begin
              mode_d = M_IDLE;
            end else begin
            end
          end
          default: begin mode_d = M_IDLE; sts_o.again = 1'b1; end
        endcase
        if (sts_o.is_error) begin
          halt_d = 1'b1; mode_d = M_IDLE;
          tone_d = '0; retr_d = 1'b0; gt_d = '0; tt_d = '0; tied_d = 1'b0;
        end
      end
    end

    // One restoring-division step
    if (cmd_i.div_step) begin
      if (sub_w[17]) begin
        rem_d = rem_try;
        quo_d = {quo_q[21:0], 1'b0};
      end else begin
        rem_d = sub_w[16:0];
        quo_d = {quo_q[21:0], 1'b1};
      end
      dcnt_d = dcnt_q + 5'd1;
      if (dcnt_q == 5'd22) begin
        sts_o.div_done = 1'b1;
        if (dpurp_q == DivLen) begin
          // Length result is ready; the byte is examined again
          if (mode_q == M_L_DOT) dlen_d = quo_d[15:0];
          else plen_d = quo_d[15:0];
        end
      end
    end

    // Gate, tone and retrigger
    if (cmd_i.gate_calc) begin
      pitch_w = prest_q ? 8'd0 : ppitch_q;
      gated   = !prest_q && (gate_q < 8'd8) && !dtied_q;
      gprod   = quo_q * gate_q;
      // pitch / 12 by reciprocal multiply, exact for 0..255
      oc_mul  = {11'b0, pitch_w} * 19'd171;
      oc      = oc_mul[15:11];
      pc_w    = pitch_w - {oc, 3'b0} - {1'b0, oc, 2'b0};
      pc      = pc_w[3:0];
      shamt   = (oc >= 5'd17) ? 5'd0 : 5'd17 - oc;
      kind_d  = prest_q ? EvRest : EvNote;
      tone_d  = prest_q ? 31'd0 : 31'(tone_tab(pc) >> shamt);
      retr_d  = (pitch_w != prev_q);
      tt_d    = {1'b0, quo_q};
      gt_d    = prest_q ? 24'd0 : gated ? gprod[26:3] : {1'b0, quo_q};
      tied_d  = dtied_q;
      prev_d  = gated ? 8'd0 : pitch_w;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octave_q <= 4'd4; dlen_q <= 16'd48; tempo_q <= 16'd120; gate_q <= 8'd7;
      prev_q <= '0; mode_q <= M_IDLE; acc_q <= '0; ppitch_q <= '0; prest_q <= 1'b0;
      plen_q <= '0; lyr_q <= '0; halt_q <= 1'b0; dcnt_q <= '0; dpurp_q <= DivTicks;
      dtied_q <= 1'b0;
    end else begin
      octave_q <= octave_d; dlen_q <= dlen_d; tempo_q <= tempo_d; gate_q <= gate_d;
      prev_q <= prev_d; mode_q <= mode_d; acc_q <= acc_d; ppitch_q <= ppitch_d;
      prest_q <= prest_d; plen_q <= plen_d; lyr_q <= lyr_d; halt_q <= halt_d;
      dcnt_q <= dcnt_d; dpurp_q <= dpurp_d; dtied_q <= dtied_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) byte_q <= mml_byte_i;
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    kind_q <= kind_d; tone_q <= tone_d; retr_q <= retr_d;
    gt_q <= gt_d; tt_q <= tt_d; tied_q <= tied_d;
  end

  assign event_kind_o  = kind_q;
  assign tone_value_o  = tone_q;
  assign retrigger_o   = retr_q;
  assign gate_ticks_o  = gt_q;
  assign total_ticks_o = tt_q;
  assign tied_o        = tied_q;
endmodule
`default_nettype wire

// File: src/mml_note_sequencer.sv
`default_nettype none
// Sequence: a byte that gives no event is accepted, then parsed, and parsed again per re-examination.
// out_valid rises after the parse step for an error, and for a note after parse, 23-step divide by
// tempo and gate step, with a 23-step 192/n divide and a second parse first for a length number.
// One byte at a time: the byte that ends an untied note is parsed again once its event is taken,
// before the next byte is accepted.
// Reset: asynchronous, active low; octave 4, length 48, tempo 120, gate 7/8.
module mml_note_sequencer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  mml_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       event_kind_o,
  output logic [30:0]      tone_value_o,
  output logic             retrigger_o,
  output logic [23:0]      gate_ticks_o,
  output logic [23:0]      total_ticks_o,
  output logic             tied_o
);
  import mml_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mml_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  mml_dp u_dp (
    .clk_i, .rst_ni, .mml_byte_i, .cmd_i(cmd), .sts_o(sts),
    .event_kind_o, .tone_value_o, .retrigger_o, .gate_ticks_o, .total_ticks_o, .tied_o
  );
endmodule
`default_nettype wire
